>>> design/cesc_pkg.sv
// Shared types and constants for the C string literal escaper.
package cesc_pkg;

  localparam int unsigned MaxBytes = 5;
  localparam int unsigned CntW = $clog2(MaxBytes + 1);
  localparam int unsigned IdxW = $clog2(MaxBytes);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW = $clog2(QueueDepth);
  localparam int unsigned QCntW = $clog2(QueueDepth + 1);

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChApos = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChBel = 8'h07;
  localparam logic [7:0] ChBs = 8'h08;
  localparam logic [7:0] ChHt = 8'h09;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChVt = 8'h0B;
  localparam logic [7:0] ChFf = 8'h0C;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowB = 8'h62;
  localparam logic [7:0] ChLowF = 8'h66;
  localparam logic [7:0] ChLowN = 8'h6E;
  localparam logic [7:0] ChLowR = 8'h72;
  localparam logic [7:0] ChLowT = 8'h74;
  localparam logic [7:0] ChLowV = 8'h76;
  localparam logic [4:0] OctHigh = 5'b00110;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
  } cesc_entry_t;

  typedef struct packed {
    logic        valid;
    cesc_entry_t entry;
  } cesc_head_t;

endpackage

>>> design/cesc_front.sv
// Front end: accepts source bytes and expands each into its escaped byte sequence.
module cesc_front import cesc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        terminator_i,
  input  logic        full_i,
  output logic        push_o,
  output cesc_entry_t entry_o
);

  logic string_open_q, string_open_d;
  logic [CntW-1:0] n;
  logic [MaxBytes-1:0][7:0] seq;

  assign in_ready_o = !full_i;
  assign push_o = in_valid_i && !full_i;

  always_comb begin
    seq = '0;
    n = '0;
    if (!string_open_q) begin
      seq[0] = ChQuote;
      n = CntW'(1);
    end
    if (terminator_i) begin
      seq[n[IdxW-1:0]] = ChQuote;
      n = n + CntW'(1);
    end else begin
      case (ch_i)
        ChApos, ChQuote, ChBslash: begin
          seq[n[IdxW-1:0]] = ChBslash;
          seq[n[IdxW-1:0] + IdxW'(1)] = ch_i;
          n = n + CntW'(2);
        end
        ChBel, ChBs, ChFf, ChLf, ChCr, ChHt, ChVt: begin
          seq[n[IdxW-1:0]] = ChBslash;
          case (ch_i)
            ChBel:   seq[n[IdxW-1:0] + IdxW'(1)] = ChLowA;
            ChBs:    seq[n[IdxW-1:0] + IdxW'(1)] = ChLowB;
            ChFf:    seq[n[IdxW-1:0] + IdxW'(1)] = ChLowF;
            ChLf:    seq[n[IdxW-1:0] + IdxW'(1)] = ChLowN;
            ChCr:    seq[n[IdxW-1:0] + IdxW'(1)] = ChLowR;
            ChHt:    seq[n[IdxW-1:0] + IdxW'(1)] = ChLowT;
            default: seq[n[IdxW-1:0] + IdxW'(1)] = ChLowV;
          endcase
          n = n + CntW'(2);
        end
        default: begin
          if (ch_i >= ChSpace && ch_i <= ChTilde) begin
            seq[n[IdxW-1:0]] = ch_i;
            n = n + CntW'(1);
          end else begin
            seq[n[IdxW-1:0]] = ChBslash;
            n = n + CntW'(1);
            if (ch_i[7:6] != 2'b00) begin
              seq[n[IdxW-1:0]] = {OctHigh, 1'b0, ch_i[7:6]};
              n = n + CntW'(1);
            end
            if (ch_i[7:3] != 5'b00000) begin
              seq[n[IdxW-1:0]] = {OctHigh, ch_i[5:3]};
              n = n + CntW'(1);
            end
            seq[n[IdxW-1:0]] = {OctHigh, ch_i[2:0]};
            n = n + CntW'(1);
          end
        end
      endcase
    end
  end

  assign entry_o.bytes = seq;
  assign entry_o.cnt = n;

  always_comb begin
    string_open_d = string_open_q;
    if (push_o) begin
      string_open_d = !terminator_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      string_open_q <= 1'b0;
    end else begin
      string_open_q <= string_open_d;
    end
  end

endmodule

>>> design/cesc_queue.sv
// Short queue of expanded byte sequences between the front and back ends.
module cesc_queue import cesc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  cesc_entry_t entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output cesc_head_t  head_o
);

  cesc_entry_t mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic do_pop;

  assign full_o = (count_q == QCntW'(QueueDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_pop = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + QCntW'(1);
      2'b01:   count_d = count_q - QCntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

endmodule

>>> design/cesc_back.sv
// Back end: sends the bytes of the queue head one per transfer and marks the last.
module cesc_back import cesc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cesc_head_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic [IdxW-1:0] idx_q, idx_d;
  logic xfer;

  assign out_valid_o = head_i.valid;
  assign out_byte_o = head_i.entry.bytes[idx_q];
  assign out_last_o = ({1'b0, idx_q} + (IdxW + 1)'(1)) ==
                      (IdxW + 1)'(head_i.entry.cnt);
  assign xfer = out_valid_o && out_ready_i;
  assign pop_o = xfer && out_last_o;

  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      idx_d = out_last_o ? '0 : idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

>>> design/c_string_literal_escaper.sv
// Top level of the C string literal escaper.
// Each expanded sequence is registered in the queue before it is offered.
// Throughput: one input item per cycle when each expands to one byte and the
// output is ready; an item of N bytes is sent one byte per cycle while ready.
// A two-entry queue parts the front from the back end.
// Reset clears the open-string flag, the queue and the byte index.
module c_string_literal_escaper import cesc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       terminator_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  cesc_entry_t entry;
  cesc_head_t  head;
  logic push, full, pop;

  cesc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ch_i         (ch_i),
    .terminator_i (terminator_i),
    .full_i       (full),
    .push_o       (push),
    .entry_o      (entry)
  );

  cesc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head)
  );

  cesc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

>>> design/cesc_checker.sv
// Port-level assertions for the C string literal escaper and their bind.
module cesc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(out_last_o))
    else $error("Stalled output transfer changed.");

  a_seq_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_last_o |=> out_valid_o)
    else $error("Byte sequence broke off before its last byte.");

  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("Accepted input item produced no output byte.");

endmodule

bind c_string_literal_escaper cesc_checker u_cesc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);

>>> test/c_string_literal_escaper_tb.sv
// Testbench for the C string literal escaper: random strings, handshake stalls, scoreboard.
class escape_scoreboard;
  localparam logic [7:0] DigitZero = 8'h30;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } lit_byte_t;

  lit_byte_t   expected_q[$];
  bit          string_open;
  int unsigned mismatches;

  function void push_byte(logic [7:0] value);
    lit_byte_t e;
    e.value = value;
    e.last = 1'b0;
    expected_q.push_back(e);
  endfunction

  function void push_escape(logic [7:0] value);
    push_byte(cesc_pkg::ChBslash);
    push_byte(value);
  endfunction

  function void note_transfer(logic [7:0] ch, logic term);
    lit_byte_t e;
    if (!string_open) push_byte(cesc_pkg::ChQuote);
    if (term) begin
      push_byte(cesc_pkg::ChQuote);
      string_open = 1'b0;
    end else begin
      string_open = 1'b1;
      case (ch)
        cesc_pkg::ChApos, cesc_pkg::ChQuote, cesc_pkg::ChBslash: push_escape(ch);
        cesc_pkg::ChBel: push_escape(cesc_pkg::ChLowA);
        cesc_pkg::ChBs: push_escape(cesc_pkg::ChLowB);
        cesc_pkg::ChFf: push_escape(cesc_pkg::ChLowF);
        cesc_pkg::ChLf: push_escape(cesc_pkg::ChLowN);
        cesc_pkg::ChCr: push_escape(cesc_pkg::ChLowR);
        cesc_pkg::ChHt: push_escape(cesc_pkg::ChLowT);
        cesc_pkg::ChVt: push_escape(cesc_pkg::ChLowV);
        default: begin
          if (ch >= cesc_pkg::ChSpace && ch <= cesc_pkg::ChTilde) begin
            push_byte(ch);
          end else begin
            push_byte(cesc_pkg::ChBslash);
            if (ch >= 8'd64) push_byte(DigitZero + {6'd0, ch[7:6]});
            if (ch >= 8'd8) push_byte(DigitZero + {5'd0, ch[5:3]});
            push_byte(DigitZero + {5'd0, ch[2:0]});
          end
        end
      endcase
    end
    e = expected_q.pop_back();
    e.last = 1'b1;
    expected_q.push_back(e);
  endfunction

  function void report(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  function void check_byte(logic [7:0] value, logic last);
    lit_byte_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("byte %h last %b with nothing pending", value, last));
    end else begin
      e = expected_q.pop_front();
      if (e.value !== value || e.last !== last) begin
        report($sformatf("expected byte %h last %b, got byte %h last %b",
                         e.value, e.last, value, last));
      end
    end
  endfunction
endclass

module c_string_literal_escaper_tb;
  import cesc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ItemTarget = 360;
  localparam int unsigned QuietAfter = 300;
  localparam int unsigned HoldAfter = 100;
  localparam int unsigned HoldCycles = 80;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] ch_i;
  logic       terminator_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  escape_scoreboard sb = new();
  int unsigned      sent_count;
  int unsigned      cycles;
  bit               quiet;
  bit               long_hold_req;
  bit               hold_issued;

  c_string_literal_escaper dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .ch_i,
    .terminator_i,
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .out_last_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_byte(out_byte_o, out_last_o);
  end

  // The receiver stalls in short random bursts, plus one long hold-off on request.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = HoldCycles - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [7:0] ch, input logic term);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i <= ch;
    terminator_i <= term;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_transfer(ch, term);
    sent_count++;
    if (sent_count >= QuietAfter) quiet = 1'b1;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] value;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: value = 8'($urandom_range(ChSpace, ChTilde));
      5, 6: begin
        case ($urandom_range(0, 9))
          0: value = ChQuote;
          1: value = ChApos;
          2: value = ChBslash;
          3: value = ChBel;
          4: value = ChBs;
          5: value = ChHt;
          6: value = ChLf;
          7: value = ChVt;
          8: value = ChFf;
          default: value = ChCr;
        endcase
      end
      default: value = 8'($urandom);
    endcase
    return value;
  endfunction

  initial begin
    int unsigned len;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    ch_i = 8'h00;
    terminator_i = 1'b0;
    sent_count = 0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
    hold_issued = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: empty literal first, field extremes, every escape class.
    send_item(8'($urandom), 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(ChQuote, 1'b0);
    send_item(ChApos, 1'b0);
    send_item(ChBslash, 1'b0);
    send_item(ChBel, 1'b0);
    send_item(ChBs, 1'b0);
    send_item(ChHt, 1'b0);
    send_item(ChLf, 1'b0);
    send_item(ChVt, 1'b0);
    send_item(ChFf, 1'b0);
    send_item(ChCr, 1'b0);
    send_item(ChSpace, 1'b0);
    send_item(ChTilde, 1'b0);
    send_item(8'h21, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h06, 1'b0);
    send_item(8'h1F, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b1);
    send_item(8'h41, 1'b0);
    send_item(8'h00, 1'b1);

    while (sent_count < ItemTarget) begin
      if (!hold_issued && sent_count >= HoldAfter) begin
        hold_issued = 1'b1;
        long_hold_req = 1'b1;
      end
      if ($urandom_range(0, 5) == 0) begin
        len = $urandom_range(1, 8);
        repeat (len) send_item(8'($urandom), 1'($urandom));
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        repeat (len) send_item(pick_byte(), 1'b0);
        send_item(8'($urandom), 1'b1);
      end
    end
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> c_string_literal_escaper.f
design/cesc_pkg.sv
design/cesc_front.sv
design/cesc_queue.sv
design/cesc_back.sv
design/c_string_literal_escaper.sv
design/cesc_checker.sv
test/c_string_literal_escaper_tb.sv
